@@ hw/rtl/fsrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrf_pkg: shared types, constants and helpers
// Report record, register indexes, reset values and the per-field helpers
// used by the fan status report framer.
// ----------------------------------------------------------------------------
package fsrf_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_REPORT_PERIOD = 2'd0;
	localparam logic [1:0] CFG_VOLT_TOL      = 2'd1;
	localparam logic [1:0] CFG_CONFIRM_CNT   = 2'd2;

	// Configuration reset values
	localparam logic [15:0] RST_REPORT_PERIOD = 16'd1000;
	localparam logic [15:0] RST_VOLT_TOL      = 16'd400;
	localparam logic [3:0]  RST_CONFIRM_CNT   = 4'd3;

	// Input mode codes
	localparam logic [1:0] MODE_HEATING   = 2'd1;
	localparam logic [1:0] MODE_EMERGENCY = 2'd2;

	// Status byte mode field codes
	localparam logic [1:0] ST_MODE_NORMAL    = 2'b00;
	localparam logic [1:0] ST_MODE_DEAD      = 2'b01;
	localparam logic [1:0] ST_MODE_HEATING   = 2'b10;
	localparam logic [1:0] ST_MODE_EMERGENCY = 2'b11;

	// Report queue geometry
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_CW    = 2;

	// Byte positions within a report
	localparam logic [1:0] BYTE_STATUS = 2'd0;
	localparam logic [1:0] BYTE_TEMP_A = 2'd1;
	localparam logic [1:0] BYTE_TEMP_B = 2'd2;
	localparam logic [1:0] BYTE_TEMP_C = 2'd3;

	typedef struct packed {
		logic [7:0] status;
		logic [7:0] temp_a;
		logic [7:0] temp_b;
		logic [7:0] temp_c;
	} report_t;

	// Integer part of a Q12.4 value, truncated toward zero, saturated to int8
	function automatic logic [7:0] temp_to_byte(input logic signed [15:0] raw);
		logic signed [15:0] adj;
		logic signed [11:0] q;
		logic [7:0] res;
		adj = raw[15] ? (raw + 16'sd15) : raw;
		q = adj[15:4];
		if (q > 12'sd127) begin
			res = 8'h7F;
		end else if (q < -12'sd128) begin
			res = 8'h80;
		end else begin
			res = q[7:0];
		end
		return res;
	endfunction

	// |target - meas| > tol, exact on 17 bits
	function automatic logic volt_bad(input logic [15:0] target, input logic [15:0] meas,
			input logic [15:0] tol);
		logic [16:0] d;
		logic [16:0] mag;
		d = {1'b0, target} - {1'b0, meas};
		mag = d[16] ? (17'd0 - d) : d;
		return mag > {1'b0, tol};
	endfunction

endpackage

@@ hw/rtl/fsrf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrf_front: tick counter and status classifier
// Holds the configuration registers, counts ticks, and on each report tick
// builds the confirmed status byte and the temperature bytes.
// ----------------------------------------------------------------------------
module fsrf_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic                   tick,
	input  logic [1:0]             mode,
	input  logic                   startup_fans_dead,
	input  logic [2:0]             fan_enable_mask,
	input  logic [2:0]             fan_fail_mask,
	input  logic [15:0]            target_voltage,
	input  logic [15:0]            fan1_voltage,
	input  logic [15:0]            fan2_voltage,
	input  logic [15:0]            fan3_voltage,
	input  logic signed [15:0]     temp_a,
	input  logic signed [15:0]     temp_b,
	input  logic signed [15:0]     temp_c,
	output logic                   rpt_push,
	output fsrf_pkg::report_t      rpt_data
);

	logic [15:0] period_q;
	logic [15:0] tol_q;
	logic [3:0]  confirm_q;
	logic [15:0] tick_cnt_q;
	logic [7:0]  prev_status_q;
	logic [3:0]  chg_cnt_q;

	logic [15:0] tick_next;
	logic        report;
	logic [1:0]  st_mode;
	logic [2:0]  alarm;
	logic [7:0]  st_raw;
	logic [7:0]  st_final;
	logic [3:0]  chg_inc;
	logic [3:0]  chg_next;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= fsrf_pkg::RST_REPORT_PERIOD;
			tol_q     <= fsrf_pkg::RST_VOLT_TOL;
			confirm_q <= fsrf_pkg::RST_CONFIRM_CNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fsrf_pkg::CFG_REPORT_PERIOD: period_q  <= cfg_data;
				fsrf_pkg::CFG_VOLT_TOL:      tol_q     <= cfg_data;
				fsrf_pkg::CFG_CONFIRM_CNT:   confirm_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Decide whether this tick closes a report period
	assign tick_next = tick_cnt_q + 16'd1;
	assign report    = tick && !(tick_next < period_q);

	// Build the raw status byte
	always_comb begin
		if (startup_fans_dead) begin
			st_mode = fsrf_pkg::ST_MODE_DEAD;
		end else if (mode == fsrf_pkg::MODE_EMERGENCY) begin
			st_mode = fsrf_pkg::ST_MODE_EMERGENCY;
		end else if (mode == fsrf_pkg::MODE_HEATING) begin
			st_mode = fsrf_pkg::ST_MODE_HEATING;
		end else begin
			st_mode = fsrf_pkg::ST_MODE_NORMAL;
		end
		alarm[0] = fan_fail_mask[0] ||
			(fan_enable_mask[0] && fsrf_pkg::volt_bad(target_voltage, fan1_voltage, tol_q));
		alarm[1] = fan_fail_mask[1] ||
			(fan_enable_mask[1] && fsrf_pkg::volt_bad(target_voltage, fan2_voltage, tol_q));
		alarm[2] = fan_fail_mask[2] ||
			(fan_enable_mask[2] && fsrf_pkg::volt_bad(target_voltage, fan3_voltage, tol_q));
		st_raw = {st_mode, alarm[2], fan_enable_mask[2], alarm[1], fan_enable_mask[1],
			alarm[0], fan_enable_mask[0]};
	end

	// Confirm a changed byte only after enough differing reports
	assign chg_inc = chg_cnt_q + 4'd1;
	always_comb begin
		st_final = st_raw;
		chg_next = chg_cnt_q;
		if (st_raw != prev_status_q) begin
			if (chg_inc >= confirm_q) begin
				chg_next = 4'd0;
			end else begin
				chg_next = chg_inc;
				st_final = prev_status_q;
			end
		end
	end

	// Advance tick count and status history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q    <= '0;
			prev_status_q <= '0;
			chg_cnt_q     <= '0;
		end else if (tick) begin
			if (report) begin
				tick_cnt_q    <= '0;
				prev_status_q <= st_final;
				chg_cnt_q     <= chg_next;
			end else begin
				tick_cnt_q <= tick_next;
			end
		end
	end

	assign rpt_push = report;
	assign rpt_data = '{
		status: st_final,
		temp_a: fsrf_pkg::temp_to_byte(temp_a),
		temp_b: fsrf_pkg::temp_to_byte(temp_b),
		temp_c: fsrf_pkg::temp_to_byte(temp_c)
	};

endmodule

@@ hw/rtl/fsrf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrf_queue: report queue
// Short first-in first-out buffer of finished reports between the
// classifier and the byte serializer.
// ----------------------------------------------------------------------------
module fsrf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  fsrf_pkg::report_t    wr_data,
	input  logic                 rd_en,
	output fsrf_pkg::report_t    rd_data,
	output logic                 q_full,
	output logic                 q_empty
);

	fsrf_pkg::report_t               mem_q [fsrf_pkg::QUEUE_DEPTH];
	logic [fsrf_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [fsrf_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [fsrf_pkg::QUEUE_CW-1:0]   count_q;

	assign q_full  = (count_q == fsrf_pkg::QUEUE_CW'(fsrf_pkg::QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store incoming reports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/fsrf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrf_back: report serializer
// Takes one report at a time from the queue and presents its four bytes
// on the result side, one beat per byte.
// ----------------------------------------------------------------------------
module fsrf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  fsrf_pkg::report_t    q_data,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic [7:0]           tx_byte,
	output logic                 last_byte
);

	fsrf_pkg::report_t rpt_q;
	logic [1:0]        idx_q;
	logic              busy_q;
	logic              take;
	logic              done;

	assign take  = busy_q && pop;
	assign done  = take && (idx_q == fsrf_pkg::BYTE_TEMP_C);
	assign q_pop = (!busy_q || done) && !q_empty;

	// Load a report, step through its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= fsrf_pkg::BYTE_STATUS;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= fsrf_pkg::BYTE_STATUS;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Hold the report payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rpt_q <= q_data;
		end
	end

	// Select the current byte
	always_comb begin
		unique case (idx_q)
			fsrf_pkg::BYTE_STATUS: tx_byte = rpt_q.status;
			fsrf_pkg::BYTE_TEMP_A: tx_byte = rpt_q.temp_a;
			fsrf_pkg::BYTE_TEMP_B: tx_byte = rpt_q.temp_b;
			fsrf_pkg::BYTE_TEMP_C: tx_byte = rpt_q.temp_c;
			default:               tx_byte = rpt_q.status;
		endcase
	end

	assign empty     = !busy_q;
	assign last_byte = (idx_q == fsrf_pkg::BYTE_TEMP_C);

endmodule

@@ hw/rtl/fan_status_report_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_status_report_framer: fan status report framer
// Counts timer ticks and frames a four-byte status report every period.
// ----------------------------------------------------------------------------
// Usage:
//   Input side: drive one tick with its readings and raise push; the tick is
//   taken on a clock edge with push high and full low. Ticks are taken every
//   cycle while the two-entry report queue has room.
//   Result side: while empty is low, tx_byte/last_byte show the oldest byte;
//   pop on a cycle with empty low takes it. A report is the status byte then
//   temp_a, temp_b, temp_c, with last_byte set on the fourth.
//   A reporting tick writes its report into the queue; when the serializer
//   is free it loads the report into its register and shows the status
//   byte. Throughput: one byte per cycle while pop is held, set by the
//   serializer's single-byte output; ticks closing no report produce nothing.
//   A stalled receiver holds the current byte; the queue then fills and full
//   rises, holding off further ticks.
//   Configuration: cfg_valid with cfg_index/cfg_data, always ready; write
//   only while the block is idle. Index 3 is ignored.
//   Reset: period 1000, tolerance 400, confirm count 3; tick count, last
//   status and change counter cleared; queue and output empty.
// ----------------------------------------------------------------------------
module fan_status_report_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          mode,
	input  logic                startup_fans_dead,
	input  logic [2:0]          fan_enable_mask,
	input  logic [2:0]          fan_fail_mask,
	input  logic [15:0]         target_voltage,
	input  logic [15:0]         fan1_voltage,
	input  logic [15:0]         fan2_voltage,
	input  logic [15:0]         fan3_voltage,
	input  logic signed [15:0]  temp_a,
	input  logic signed [15:0]  temp_b,
	input  logic signed [15:0]  temp_c,
	input  logic                pop,
	output logic                empty,
	output logic [7:0]          tx_byte,
	output logic                last_byte
);

	logic              tick;
	logic              rpt_push;
	fsrf_pkg::report_t rpt_data;
	fsrf_pkg::report_t q_data;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign tick      = push && !q_full;

	fsrf_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.tick              (tick),
		.mode              (mode),
		.startup_fans_dead (startup_fans_dead),
		.fan_enable_mask   (fan_enable_mask),
		.fan_fail_mask     (fan_fail_mask),
		.target_voltage    (target_voltage),
		.fan1_voltage      (fan1_voltage),
		.fan2_voltage      (fan2_voltage),
		.fan3_voltage      (fan3_voltage),
		.temp_a            (temp_a),
		.temp_b            (temp_b),
		.temp_c            (temp_c),
		.rpt_push          (rpt_push),
		.rpt_data          (rpt_data)
	);

	fsrf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rpt_push),
		.wr_data (rpt_data),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	fsrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.tx_byte   (tx_byte),
		.last_byte (last_byte)
	);

endmodule

@@ hw/rtl/fsrf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrf_checker: port-level checks
// Watches the framer's queue-style ports for framing and flow-control slips.
// ----------------------------------------------------------------------------
module fsrf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        pop,
	input logic        empty,
	input logic [7:0]  tx_byte,
	input logic        last_byte
);

	// A waiting byte holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(tx_byte) && $stable(last_byte)))
		else $error("result beat changed while stalled");

	// Bytes of one report follow without a gap
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_byte) |=> !empty)
		else $error("report broken before its last byte");

	// Full only rises after an accepted tick
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted tick");

	// A taken last byte is never followed straight by another last byte
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && last_byte) |=> (empty || !last_byte))
		else $error("last byte repeated");

endmodule

bind fan_status_report_framer fsrf_checker u_fsrf_checker (.*);
